/* rtl/core/olss_pkg.sv */
// ----------------------------------------------------------------------------
// olss_pkg
// Shared types and constants of the overdub loop sample store.
// ----------------------------------------------------------------------------
package olss_pkg;

  localparam int unsigned LoopDepth = 131072;
  localparam int unsigned AddrW     = $clog2(LoopDepth);
  localparam int unsigned IdxW      = 18;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned GainW     = 16;

  // unity gain in Q1.15
  localparam logic [GainW-1:0] UnityGain = GainW'(32768);

  typedef enum logic [1:0] {
    CmdRead    = 2'd0,
    CmdOverdub = 2'd1,
    CmdErase   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [IdxW-1:0]           index;
    logic signed [SampleW-1:0] write_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] read_sample;
    logic                      out_of_range;
  } out_item_t;

endpackage

/* rtl/core/olss_ram.sv */
// ----------------------------------------------------------------------------
// olss_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module olss_ram #(
  parameter  int unsigned Depth = 1024,
  parameter  int unsigned Width = 16,
  localparam int unsigned AW    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/olss_calc.sv */
// ----------------------------------------------------------------------------
// olss_calc
// Gain scaling and saturating overdub sum of one stored sample, registered.
// ----------------------------------------------------------------------------
module olss_calc
  import olss_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [SampleW-1:0] stored_i,
  input  logic signed [SampleW-1:0] write_sample_i,
  input  logic [GainW-1:0]          gain_i,
  output logic signed [SampleW-1:0] scaled_o,
  output logic signed [SampleW-1:0] sum_o
);

  logic [GainW-1:0]           gain_c;
  logic signed [2*SampleW:0]  prod_c;
  logic signed [SampleW:0]    add_c;
  logic signed [SampleW-1:0]  sat_c;
  logic signed [SampleW-1:0]  scaled_q;
  logic signed [SampleW-1:0]  sum_q;

  always_comb begin
    gain_c = (gain_i > UnityGain) ? UnityGain : gain_i;
    prod_c = stored_i * $signed({1'b0, gain_c});
    add_c  = {write_sample_i[SampleW-1], write_sample_i} + {stored_i[SampleW-1], stored_i};
    if (add_c[SampleW] != add_c[SampleW-1]) begin
      sat_c = add_c[SampleW] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      sat_c = add_c[SampleW-1:0];
    end
  end

  // arithmetic shift by 15 = floor; product never leaves the 16-bit range
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scaled_q <= prod_c[2*SampleW-2:SampleW-1];
      sum_q    <= sat_c;
    end
  end

  assign scaled_o = scaled_q;
  assign sum_o    = sum_q;

endmodule

/* rtl/core/overdub_loop_sample_store.sv */
// ----------------------------------------------------------------------------
// overdub_loop_sample_store
// One loop layer of Q1.15 audio samples with gain read, overdub and erase.
// ----------------------------------------------------------------------------
// A read or overdub transaction passes from acceptance to a result in the
// output register through memory read, then multiply/saturating add, then the
// result and the write-back land together. The next transaction is accepted
// in the cycle after the write-back at the earliest, so no new transaction is
// taken while one is in flight, owing to the single read-modify-write sequence
// on the sample memory; a result held by a stalled output keeps the block in
// the write-back step until it is taken. After reset and after every erase the
// block sweeps all LoopDepth (131072) entries of the memory to zero, one entry
// per cycle, and accepts no transaction meanwhile; gain writes are taken at any
// time. The erase result itself enters the output register as the sweep starts.
module overdub_loop_sample_store
  import olss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [GainW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRead  = 2'd1;
  localparam logic [1:0] StWrite = 2'd2;
  localparam logic [1:0] StClear = 2'd3;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(LoopDepth - 1);

  logic [1:0]                state_q, state_d;
  logic [AddrW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [GainW-1:0]          gain_q;
  logic [1:0]                cmd_q;
  logic [AddrW-1:0]          addr_q;
  logic signed [SampleW-1:0] ws_q;
  logic                      oor_q;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  logic                      in_acc;
  logic                      oor_c;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_waddr;
  logic [SampleW-1:0]        ram_wdata;
  logic [SampleW-1:0]        ram_rdata;
  logic signed [SampleW-1:0] scaled;
  logic signed [SampleW-1:0] sum;
  logic                      out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign oor_c      = {1'b0, in_i.index} >= (IdxW+1)'(LoopDepth);
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= UnityGain;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= in_i.cmd;
      addr_q <= in_i.index[AddrW-1:0];
      ws_q   <= in_i.write_sample;
      oor_q  <= oor_c;
    end
  end

  olss_ram #(
    .Depth (LoopDepth),
    .Width (SampleW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_i.index[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  olss_calc u_calc (
    .clk_i          (clk_i),
    .en_i           (state_q == StRead),
    .stored_i       ($signed(ram_rdata)),
    .write_sample_i (ws_q),
    .gain_i         (gain_q),
    .scaled_o       (scaled),
    .sum_o          (sum)
  );

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = sum;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = StWrite;
      end
      StWrite: begin
        // repeated write while stalled stores the same word again
        ram_we = (cmd_q == CmdOverdub) && !oor_q;
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.read_sample     = ((cmd_q == CmdRead) && !oor_q) ? scaled : '0;
          out_d.out_of_range    = oor_q && ((cmd_q == CmdRead) || (cmd_q == CmdOverdub));
          state_d               = (cmd_q == CmdErase) ? StClear : StIdle;
        end
      end
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        if (clr_cnt_q == LastAddr) begin
          clr_cnt_d = '0;
          state_d   = StIdle;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* rtl/core/olss_checker.sv */
// ----------------------------------------------------------------------------
// olss_port_checks
// Port-level checks of the overdub loop sample store, bound to the top level.
// ----------------------------------------------------------------------------
module olss_port_checks
  import olss_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_o
);

  // result stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transaction completed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o))
    else $error("result changed while stalled");

  // an out-of-range result never carries a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_of_range |-> out_o.read_sample == '0)
    else $error("out-of-range result with nonzero sample");

  // an accepted erase keeps input blocked in the read and write-back steps that follow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.cmd == CmdErase) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input accepted right after erase");

endmodule

bind overdub_loop_sample_store olss_port_checks u_olss_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

/* dv/olss_checker.sv */
// ----------------------------------------------------------------------------
// olss_checker
// Watches the command and result channels of the overdub loop sample store,
// keeps a shadow copy of the sample store and the gain, predicts the result
// of every accepted command and compares it with the result that comes out.
// ----------------------------------------------------------------------------
module olss_checker
  import olss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [GainW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_i,
  output int               fail_count_o,
  output int               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // entries never written read as zero, erase just empties the array
  logic signed [SampleW-1:0] sample_store [int];
  logic [GainW-1:0]          play_gain;
  out_item_t                 expected_results [$];
  int                        fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_results.size();

  function automatic logic signed [SampleW-1:0] stored_at(int addr);
    return sample_store.exists(addr) ? sample_store[addr] : '0;
  endfunction

  function automatic logic signed [SampleW-1:0] sat_sample(int v);
    if (v > 32767) return SampleW'(32767);
    if (v < -32768) return SampleW'(-32768);
    return SampleW'(v);
  endfunction

  // applies one command to the shadow store and returns its result
  function automatic out_item_t predict_access(in_item_t item);
    out_item_t res;
    int        addr;
    int        prod;
    int        g;
    res  = '0;
    addr = int'(item.index);
    case (item.cmd)
      CmdRead: begin
        if (addr >= int'(LoopDepth)) begin
          res.out_of_range = 1'b1;
        end else begin
          g    = (play_gain > UnityGain) ? int'(UnityGain) : int'(play_gain);
          prod = int'(stored_at(addr)) * g;
          // arithmetic shift rounds toward minus infinity
          res.read_sample = SampleW'(prod >>> 15);
        end
      end
      CmdOverdub: begin
        if (addr >= int'(LoopDepth)) begin
          res.out_of_range = 1'b1;
        end else begin
          sample_store[addr] = sat_sample(int'(item.write_sample) + int'(stored_at(addr)));
        end
      end
      CmdErase: begin
        sample_store.delete();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_res;
    if (!rst_ni) begin
      sample_store.delete();
      expected_results.delete();
      play_gain  = UnityGain;
      fail_count = 0;
    end else begin
      if (cfg_we_i) begin
        play_gain = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_access(in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: read_sample %0d, out_of_range %0b",
                 out_i.read_sample, out_i.out_of_range);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_i.read_sample !== exp_res.read_sample) begin
            $error("read_sample: expected %0d, got %0d",
                   exp_res.read_sample, out_i.read_sample);
            fail_count++;
          end
          if (out_i.out_of_range !== exp_res.out_of_range) begin
            $error("out_of_range: expected %0b, got %0b",
                   exp_res.out_of_range, out_i.out_of_range);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the overdub loop sample store: directed corner commands, then
// random reads, overdubs and unused commands, mostly over a small set of hot
// addresses, with one erase, under several gain settings and idle patterns.
// Checking lives in olss_checker.
module tb;
  import olss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         NumPhases  = 6;
  localparam int         PhaseItems = 105;
  localparam int         MaxIndex   = (1 << IdxW) - 1;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [GainW-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_item_t         in_i        = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_item_t        out_o;
  int               fail_count;
  int               pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  overdub_loop_sample_store u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  olss_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_i         (in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i        (out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // the timeout leaves room for the reset sweep plus two erase sweeps
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic send_cmd(logic [1:0] cmd, int idx, int ws);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_i.cmd           <= cmd;
    in_i.index         <= IdxW'(idx);
    in_i.write_sample  <= SampleW'(ws);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // lets the clock advance first so the last accepted transaction is already counted
  task automatic drain_and_set_gain(logic [GainW-1:0] g);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly a hot set at both ends of the store so reads see earlier overdubs
  function automatic int pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(15);
    if (r < 75) return int'(LoopDepth) - 1 - $urandom_range(7);
    if (r < 88) return $urandom_range(MaxIndex);
    return $urandom_range(MaxIndex, int'(LoopDepth));
  endfunction

  function automatic int pick_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    if (r == 2) return $urandom_range(16) - 8;
    return $urandom_range(65535) - 32768;
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 45) send_cmd(CmdRead, pick_index(), pick_sample());
    else if (r < 93) send_cmd(CmdOverdub, pick_index(), pick_sample());
    else send_cmd(CmdUnused, pick_index(), pick_sample());
  endtask

  initial begin
    logic [GainW-1:0] gains [NumPhases];
    gains = '{16'd0, 16'hFFFF, 16'd1, 16'd32768, 16'd32767, 16'd0};
    gains[3] = GainW'($urandom_range(32768));
    gains[5] = GainW'($urandom_range(65535));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners at reset gain (unity)
    send_cmd(CmdRead, 0, 0);
    send_cmd(CmdOverdub, 0, 32767);
    send_cmd(CmdOverdub, 0, 32767);          // saturates high
    send_cmd(CmdRead, 0, -5);
    send_cmd(CmdOverdub, 1, -32768);
    send_cmd(CmdOverdub, 1, -32768);         // saturates low
    send_cmd(CmdRead, 1, 0);
    send_cmd(CmdOverdub, 2, -1);
    send_cmd(CmdRead, 2, 0);
    send_cmd(CmdOverdub, int'(LoopDepth) - 1, 12345);
    send_cmd(CmdRead, int'(LoopDepth) - 1, 0);
    send_cmd(CmdRead, int'(LoopDepth), 0);   // first index past the end
    send_cmd(CmdOverdub, int'(LoopDepth), 100);
    send_cmd(CmdRead, MaxIndex, -1);
    send_cmd(CmdOverdub, MaxIndex, -1);
    send_cmd(CmdUnused, 5, 32767);
    send_cmd(CmdUnused, MaxIndex, -1);
    send_cmd(CmdRead, 0, 0);                 // unused command left store alone
    send_cmd(CmdErase, MaxIndex, -1);
    send_cmd(CmdRead, 0, 0);
    send_cmd(CmdRead, 1, 0);
    send_cmd(CmdRead, int'(LoopDepth) - 1, 0);

    for (int p = 0; p < NumPhases; p++) begin
      drain_and_set_gain(gains[p]);
      if (p < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 67;
      end else if (p < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int k = 0; k < PhaseItems; k++) begin
        // one erase mid-run; the sweep is long, so only once
        if (p == 3 && k == PhaseItems / 2) send_cmd(CmdErase, pick_index(), pick_sample());
        else send_random();
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* overdub_loop_sample_store.f */
rtl/core/olss_pkg.sv
rtl/core/olss_ram.sv
rtl/core/olss_calc.sv
rtl/core/overdub_loop_sample_store.sv
rtl/core/olss_checker.sv
dv/olss_checker.sv
dv/tb.sv
